// ===== sv/bbe_pkg.sv =====
// Shared constants and types for the binary boundary extraction block.
// No dependencies; used by every module of the block.
package bbe_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_MASK  = 7;
  localparam int MAX_HEIGHT    = 1024;

  localparam int PIX_W    = 8;   // gray pixel, boundary value, threshold
  localparam int DIM_W    = 11;  // image_width / image_height registers
  localparam int MREG_W   = 3;   // mask_size register
  localparam int CFG_W    = 11;  // widest register
  localparam int IDXR_W   = 2;   // register index
  localparam int FLD_W    = 10;  // out_row / out_col fields
  localparam int IN_ROW_W = 11;  // input row count runs past H while draining
  localparam int OUT_TD_W = 32;

  localparam logic [IDXR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDXR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDXR_W-1:0] REG_MASK_SIZE    = 2'd2;
  localparam logic [IDXR_W-1:0] REG_THRESHOLD    = 2'd3;

  localparam logic [DIM_W-1:0]  RST_WIDTH     = 11'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT    = 11'd480;
  localparam logic [MREG_W-1:0] RST_MASK      = 3'd3;
  localparam logic [PIX_W-1:0]  RST_THRESHOLD = 8'd127;

  localparam logic [PIX_W-1:0] FG_VALUE = 8'hFF;
  localparam logic [PIX_W-1:0] BG_VALUE = 8'h00;

  // per-pixel bookkeeping that travels down the pipe with the pixel
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             interior;
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] boundary;
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
    logic             last;
  } res_t;

endpackage

// ===== sv/bbe_line_store.sv =====
// Column line store: binary history of the rows above, one word per column,
// read-modify-written once per beat. Depends on bbe_pkg.
module bbe_line_store import bbe_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_MASK  = DEF_MAX_MASK
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         upd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] upd_addr,
  input  logic                         upd_bit,
  output logic [MAX_MASK-1:0]          col_word
);

  localparam int STORE_W = (MAX_MASK > 1) ? MAX_MASK - 1 : 1;

  logic [STORE_W-1:0] mem [MAX_WIDTH];
  logic [STORE_W-1:0] rd_data_r;
  logic [STORE_W-1:0] fwd_data_r;
  logic               fwd_r;
  logic [STORE_W-1:0] old_word;
  logic [STORE_W:0]   shifted;
  logic [STORE_W-1:0] wr_data;

  // Only a one-column image reads the address written in the same cycle.
  assign old_word = fwd_r ? fwd_data_r : rd_data_r;
  assign shifted  = {old_word, upd_bit};
  assign col_word = shifted[MAX_MASK-1:0];
  assign wr_data  = shifted[STORE_W-1:0];

  always_ff @(posedge clk) begin
    if (upd_en) begin
      mem[upd_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      fwd_r      <= upd_en && (upd_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

endmodule

// ===== sv/bbe_cell.sv =====
// One window column cell: holds a binary column, passes it on each shift,
// and flags whether its masked rows are all foreground. Depends on bbe_pkg.
module bbe_cell import bbe_pkg::*; #(
  parameter int MAX_MASK = DEF_MAX_MASK
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  logic                active,
  input  logic [MAX_MASK-1:0] wmask,
  input  logic [MAX_MASK-1:0] col_in,
  output logic [MAX_MASK-1:0] col_out,
  output logic                col_ok
);

  logic [MAX_MASK-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign col_ok  = !active || ((col_r & wmask) == wmask);

endmodule

// ===== sv/bbe_out_buf.sv =====
// Two-entry result buffer between the window pipe and the output channel.
// Depends on bbe_pkg (res_t).
module bbe_out_buf import bbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/binary_boundary_extraction_top.sv =====
// Top level of the binary boundary extraction block.
// Depends on bbe_pkg, bbe_line_store, bbe_cell and bbe_out_buf.
//
// Takes one gray pixel per beat in raster order and returns one boundary beat
// per image pixel: 255 where the thresholded pixel is foreground and its
// mask_size square neighborhood holds background or leaves the image, else 0.
// Throughput is one beat per clock while the result buffer has room; the limit is
// the single read-modify-write of the column line store each beat. A result for
// pixel (r, c) comes out with the input beat that carries pixel (r+a, c+a),
// a = mask_size-1-mask_size/2, so a frame needs W*H + a*W + a input beats, the
// last ones pad beats (in_tuser set); each result then passes the stage-1
// registers, the window cells and the result buffer. The input is held off
// during a configuration write and the clock after it, and in the cycle after
// reset. The line store is not cleared after reset: stale rows only reach windows
// that overlap the top border, where the answer depends on the center pixel alone.
module binary_boundary_extraction_top import bbe_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_MASK  = DEF_MAX_MASK
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [PIX_W-1:0]    in_tdata,   // [7:0] pixel
  input  logic [0:0]          in_tuser,   // [0] pad_tick
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,  // [7:0] boundary, [17:8] out_row, [27:18] out_col
  output logic                out_tlast,  // last_of_frame
  input  logic                cfg_we,
  input  logic [IDXR_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int MSK_W    = $clog2(MAX_MASK + 1);
  localparam int IDX_W    = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
  localparam int LEAD_MAX = ((MAX_MASK - 1) / 2) * (MAX_WIDTH + 1);
  localparam int LEAD_W   = (LEAD_MAX > 0) ? $clog2(LEAD_MAX + 1) : 1;

  // configuration registers
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;
  logic [MREG_W-1:0] mask_size_r;
  logic [PIX_W-1:0]  threshold_r;
  logic              cfg_dly_r;

  // clamped geometry, recomputed every clock
  logic [WID_W-1:0]    w_c, w_r;
  logic [DIM_W-1:0]    h_c, h_r;
  logic [MSK_W-1:0]    m_c, a_c, s_c, a_r, s_r;
  logic [MAX_MASK-1:0] wmask_c, wmask_r;
  logic [LEAD_W-1:0]   a_l, w_l, lead_len_c, lead_len_r;

  // raster counters
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [FLD_W-1:0]    out_row_r, out_row_nxt;
  logic [LEAD_W-1:0]   lead_r, lead_nxt;

  logic             adv, in_acc, geo_wr;
  logic             pix_bit, emit, last, interior, col_wrap, ocol_wrap;
  logic [WID_W:0]   c_ext;
  logic [DIM_W-1:0] r_ext;
  tag_t             tag_c;

  // pipe stages
  logic             s1_valid_r, s2_valid_r;
  logic             s1_bit_r;
  logic [COL_W-1:0] s1_col_r;
  tag_t             s1_tag_r, s2_tag_r;

  logic [MAX_MASK-1:0] col_word;
  logic [MAX_MASK-1:0] cols [MAX_MASK];
  logic [MAX_MASK-1:0] col_ok;
  logic                shift, full, center, buf_full, push;
  res_t                res_c, res_out;

  // ---------------- configuration ----------------
  assign geo_wr = cfg_we && (cfg_index != REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_WIDTH;
      image_height_r <= RST_HEIGHT;
      mask_size_r    <= RST_MASK;
      threshold_r    <= RST_THRESHOLD;
      cfg_dly_r      <= 1'b1;
    end else begin
      cfg_dly_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
          REG_MASK_SIZE:    mask_size_r    <= cfg_data[MREG_W-1:0];
          REG_THRESHOLD:    threshold_r    <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (image_width_r == '0) begin
      w_c = WID_W'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_c = WID_W'(MAX_WIDTH);
    end else begin
      w_c = WID_W'(image_width_r);
    end

    if (image_height_r == '0) begin
      h_c = DIM_W'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      h_c = DIM_W'(MAX_HEIGHT);
    end else begin
      h_c = image_height_r;
    end

    if (mask_size_r == '0) begin
      m_c = MSK_W'(1);
    end else if (32'(mask_size_r) > MAX_MASK) begin
      m_c = MSK_W'(MAX_MASK);
    end else begin
      m_c = MSK_W'(mask_size_r);
    end

    s_c = m_c >> 1;
    a_c = m_c - MSK_W'(1) - s_c;
    for (int j = 0; j < MAX_MASK; j++) begin
      wmask_c[j] = (j < int'(m_c));
    end
    a_l        = LEAD_W'(a_c);
    w_l        = LEAD_W'(w_c);
    lead_len_c = a_l * w_l + a_l;
  end

  always_ff @(posedge clk) begin
    w_r        <= w_c;
    h_r        <= h_c;
    a_r        <= a_c;
    s_r        <= s_c;
    wmask_r    <= wmask_c;
    lead_len_r <= lead_len_c;
  end

  // ---------------- front end: counters ----------------
  assign adv       = !buf_full;
  assign in_tready = adv && !cfg_we && !cfg_dly_r;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pix_bit   = (in_row_r < h_r) && !in_tuser[0] && (in_tdata > threshold_r);
    emit      = (lead_r == lead_len_r);
    col_wrap  = ((WID_W'(in_col_r) + WID_W'(1)) == w_r);
    ocol_wrap = ((WID_W'(out_col_r) + WID_W'(1)) == w_r);
    r_ext     = DIM_W'(out_row_r);
    c_ext     = (WID_W + 1)'(out_col_r);
    last      = emit && (r_ext == h_r - DIM_W'(1)) && ocol_wrap;
    interior  = (r_ext >= DIM_W'(s_r)) && (c_ext >= (WID_W + 1)'(s_r)) &&
                (r_ext + DIM_W'(a_r) < h_r) &&
                (c_ext + (WID_W + 1)'(a_r) < (WID_W + 1)'(w_r));

    tag_c.emit     = emit;
    tag_c.last     = last;
    tag_c.interior = interior;
    tag_c.row      = out_row_r;
    tag_c.col      = FLD_W'(out_col_r);

    lead_nxt    = emit ? lead_r : lead_r + LEAD_W'(1);
    in_col_nxt  = col_wrap ? '0 : in_col_r + COL_W'(1);
    in_row_nxt  = col_wrap ? in_row_r + IN_ROW_W'(1) : in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      out_col_nxt = ocol_wrap ? '0 : out_col_r + COL_W'(1);
      out_row_nxt = ocol_wrap ? out_row_r + FLD_W'(1) : out_row_r;
    end
    if (last) begin
      lead_nxt    = '0;
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geo_wr) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lead_r    <= '0;
    end else if (in_acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lead_r    <= lead_nxt;
    end
  end

  // ---------------- pipe ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bit_r <= pix_bit;
      s1_col_r <= in_col_r;
      s1_tag_r <= tag_c;
    end
    if (adv) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  assign shift = adv && s1_valid_r;

  bbe_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_MASK  (MAX_MASK)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (in_col_r),
    .upd_en   (shift),
    .upd_addr (s1_col_r),
    .upd_bit  (s1_bit_r),
    .col_word (col_word)
  );

  // window: cell 0 holds the newest column
  for (genvar j = 0; j < MAX_MASK; j++) begin : g_cell
    bbe_cell #(
      .MAX_MASK (MAX_MASK)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .active  (wmask_r[j]),
      .wmask   (wmask_r),
      .col_in  ((j == 0) ? col_word : cols[(j > 0) ? j - 1 : 0]),
      .col_out (cols[j]),
      .col_ok  (col_ok[j])
    );
  end

  always_comb begin
    full           = &col_ok;
    center         = cols[IDX_W'(a_r)][IDX_W'(a_r)];
    res_c.boundary = (center && !(s2_tag_r.interior && full)) ? FG_VALUE : BG_VALUE;
    res_c.row      = s2_tag_r.row;
    res_c.col      = s2_tag_r.col;
    res_c.last     = s2_tag_r.last;
  end

  assign push = adv && s2_valid_r && s2_tag_r.emit;

  bbe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res_c),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_out)
  );

  assign out_tdata = {(OUT_TD_W - PIX_W - 2 * FLD_W)'(0), res_out.col, res_out.row,
                      res_out.boundary};
  assign out_tlast = res_out.last;

endmodule

// ===== sv/bbe_checker.sv =====
// Port-level checker for binary_boundary_extraction_top and its bind.
// Depends on bbe_pkg.
module bbe_checker import bbe_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_TD_W-1:0] out_tdata,
  input logic                out_tlast,
  input logic                cfg_we
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_cfg_block: assert property (@(posedge clk)
    cfg_we |-> !in_tready)
    else $error("input taken during a register write");

  // geometry passes the configuration register and then its clamped copy; no input in the cycle after a write
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> !in_tready)
    else $error("input taken before geometry settled");

  a_bnd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PIX_W-1:0] == FG_VALUE) || (out_tdata[PIX_W-1:0] == BG_VALUE))
    else $error("boundary value neither foreground nor background");

endmodule

bind binary_boundary_extraction_top bbe_checker u_bbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_we     (cfg_we)
);
